@@ design/pacrl_pkg.sv @@
// ----------------------------------------------------------------------------
// pacrl_pkg
// Shared types and constants of the per-address credit rate limiter.
// ----------------------------------------------------------------------------
package pacrl_pkg;

    localparam int ADDR_W     = 32;
    localparam int TICK_W     = 32;
    localparam int CREDIT_W   = 32;
    localparam int TICK_SHIFT = 7;
    localparam int SUM_W      = CREDIT_W + TICK_SHIFT + 1;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    localparam logic [1:0] REG_INITIAL_CREDIT = 2'd0;
    localparam logic [1:0] REG_CREDIT_CEILING = 2'd1;
    localparam logic [1:0] REG_PASS_COST      = 2'd2;
    localparam logic [1:0] REG_INVERT_VERDICT = 2'd3;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HEAD_RD,
        ST_HEAD_WT,
        ST_WALK_CHK,
        ST_WALK_CMP,
        ST_HIT_SUM,
        ST_HIT_UPD,
        ST_MISS,
        ST_UL_HASH,
        ST_UL_HRD,
        ST_UL_HWT,
        ST_UL_CHK,
        ST_UL_NXT,
        ST_UL_FIX,
        ST_INS_RD,
        ST_INS_WR,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic head_rd;
        logic walk_init;
        logic walk_rd;
        logic walk_cmp;
        logic hit_sum;
        logic hit_upd;
        logic miss_start;
        logic ul_hash;
        logic ul_head_rd;
        logic ul_init;
        logic ul_rd;
        logic ul_adv;
        logic ul_fix;
        logic ins_rd;
        logic ins_wr;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic src_zero;
        logic cur_end;
        logic addr_match;
        logic cur_is_slot;
        logic slot_used;
    } t_sts;

endpackage

@@ design/pacrl_req_if.sv @@
// ----------------------------------------------------------------------------
// pacrl_req_if
// Packet channel into the rate limiter.
// ----------------------------------------------------------------------------
interface pacrl_req_if import pacrl_pkg::*;;
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] source_address;
    logic [ADDR_W-1:0] dest_address;
    logic [TICK_W-1:0] now_tick;

    modport source (output valid, source_address, dest_address, now_tick, input ready);
    modport sink   (input valid, source_address, dest_address, now_tick, output ready);
endinterface

@@ design/pacrl_rsp_if.sv @@
// ----------------------------------------------------------------------------
// pacrl_rsp_if
// Verdict channel out of the rate limiter.
// ----------------------------------------------------------------------------
interface pacrl_rsp_if;
    logic valid;
    logic ready;
    logic verdict;
    logic was_new;

    modport source (output valid, verdict, was_new, input ready);
    modport sink   (input valid, verdict, was_new, output ready);
endinterface

@@ design/pacrl_ram.sv @@
// ----------------------------------------------------------------------------
// pacrl_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pacrl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ design/pacrl_dp.sv @@
// ----------------------------------------------------------------------------
// pacrl_dp
// Datapath: config registers, table memories, chain walk registers, credit math.
// ----------------------------------------------------------------------------
module pacrl_dp import pacrl_pkg::*; #(
    parameter int TABLE_ENTRIES = 256,
    parameter int HASH_BITS     = 9,
    parameter int CHAIN_LIMIT   = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic [ADDR_W-1:0]     i_source_address,
    input  logic [ADDR_W-1:0]     i_dest_address,
    input  logic [TICK_W-1:0]     i_now_tick,
    output logic                  o_verdict,
    output logic                  o_was_new,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata
);
    localparam int SW    = $clog2(TABLE_ENTRIES);
    localparam int LW    = $clog2(TABLE_ENTRIES + 1);
    localparam int NB    = 1 << HASH_BITS;
    localparam int CLR_N = (NB > TABLE_ENTRIES) ? NB : TABLE_ENTRIES;
    localparam int CW    = $clog2(CLR_N);
    localparam logic [LW-1:0] NIL = LW'(TABLE_ENTRIES);

    function automatic logic [HASH_BITS-1:0] fold_hash(input logic [ADDR_W-1:0] a);
        logic [ADDR_W-1:0] h;
        h = '0;
        for (int k = 0; k < ADDR_W; k++) begin
            if (k * HASH_BITS < ADDR_W) begin
                h = h ^ (a >> (k * HASH_BITS));
            end
        end
        return h[HASH_BITS-1:0];
    endfunction

    function automatic logic [LW-1:0] clip(input logic [LW-1:0] v);
        return (v >= NIL) ? NIL : v;
    endfunction

    logic [CREDIT_W-1:0] r_init, r_ceil, r_cost;
    logic                r_inv;
    logic [ADDR_W-1:0]   r_dst;
    logic [TICK_W-1:0]   r_now;
    logic [HASH_BITS-1:0] r_h, r_b;
    logic [LW-1:0]       r_cur, r_prev, r_last, r_count, r_steps;
    logic [SW-1:0]       r_s, r_oldest;
    logic [CW-1:0]       r_clr;
    logic [SUM_W-1:0]    r_sum;
    logic                r_verdict, r_was_new;

    logic [ADDR_W-1:0]   addr_rd;
    logic [TICK_W-1:0]   stamp_rd;
    logic [CREDIT_W-1:0] credit_rd;
    logic [LW-1:0]       link_rd, head_rd;
    logic                used_rd;

    logic                slot_re, link_re, head_re;
    logic [SW-1:0]       slot_ra;
    logic [HASH_BITS-1:0] head_ra;
    logic                head_we, link_we, used_we, data_we;
    logic [HASH_BITS-1:0] head_wa;
    logic [LW-1:0]       head_wd, link_wd;
    logic [SW-1:0]       link_wa, used_wa, data_wa;
    logic                used_wd;
    logic [TICK_W-1:0]   stamp_wd;
    logic [CREDIT_W-1:0] credit_wd;
    logic [ADDR_W-1:0]   addr_wd;

    logic                trim, clr_head, clr_used, raw, apb_wr;
    logic [CREDIT_W-1:0] clamp;
    logic [TICK_W-1:0]   diff;
    logic [LW-1:0]       nxt;

    assign apb_wr   = psel && penable && pwrite;
    assign trim     = (int'(r_count) >= CHAIN_LIMIT) && (r_last != NIL);
    assign clr_head = ({1'b0, r_clr} < (CW + 1)'(NB));
    assign clr_used = ({1'b0, r_clr} < (CW + 1)'(TABLE_ENTRIES));
    assign diff     = r_now - stamp_rd;
    assign clamp    = (r_sum > SUM_W'(r_ceil)) ? r_ceil : r_sum[CREDIT_W-1:0];
    assign raw      = (clamp >= r_cost);
    assign nxt      = clip(link_rd);

    always_comb begin
        case (paddr[3:2])
            REG_INITIAL_CREDIT: prdata = r_init;
            REG_CREDIT_CEILING: prdata = r_ceil;
            REG_PASS_COST:      prdata = r_cost;
            REG_INVERT_VERDICT: prdata = {{(APB_DATA_W-1){1'b0}}, r_inv};
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init   <= '0;
            r_ceil   <= '0;
            r_cost   <= '0;
            r_inv    <= 1'b0;
            r_oldest <= '0;
            r_clr    <= '0;
        end else begin
            if (apb_wr) begin
                case (paddr[3:2])
                    REG_INITIAL_CREDIT: r_init <= pwdata;
                    REG_CREDIT_CEILING: r_ceil <= pwdata;
                    REG_PASS_COST:      r_cost <= pwdata;
                    REG_INVERT_VERDICT: r_inv  <= pwdata[0];
                    default: ;
                endcase
            end
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.ins_wr) begin
                r_oldest <= (r_oldest == SW'(TABLE_ENTRIES - 1)) ? '0 : r_oldest + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dst     <= i_dest_address;
            r_now     <= i_now_tick;
            r_h       <= fold_hash(i_dest_address);
            r_verdict <= 1'b0;
            r_was_new <= 1'b0;
        end
        if (i_cmd.walk_init) begin
            r_cur   <= clip(head_rd);
            r_count <= '0;
            r_steps <= '0;
            r_last  <= NIL;
        end
        if (i_cmd.walk_cmp && !o_sts.addr_match) begin
            r_count <= r_count + 1'b1;
            r_steps <= r_steps + 1'b1;
            r_cur   <= nxt;
            if (nxt != NIL) begin
                r_last <= r_cur;
            end
        end
        if (i_cmd.hit_sum) begin
            r_sum <= SUM_W'(credit_rd) + SUM_W'({diff, {TICK_SHIFT{1'b0}}});
        end
        if (i_cmd.hit_upd) begin
            r_verdict <= raw ^ r_inv;
            r_was_new <= 1'b0;
        end
        if (i_cmd.miss_start) begin
            r_s <= r_oldest;
        end
        if (i_cmd.ul_hash) begin
            r_b <= fold_hash(addr_rd);
        end
        if (i_cmd.ul_init) begin
            r_cur   <= clip(head_rd);
            r_prev  <= NIL;
            r_steps <= '0;
        end
        if (i_cmd.ul_adv) begin
            r_prev  <= r_cur;
            r_cur   <= nxt;
            r_steps <= r_steps + 1'b1;
        end
        if (i_cmd.ins_wr) begin
            r_verdict <= ~r_inv;
            r_was_new <= 1'b1;
        end
    end

    always_comb begin
        slot_re = i_cmd.walk_rd || i_cmd.miss_start;
        link_re = i_cmd.walk_rd || i_cmd.ul_rd;
        slot_ra = i_cmd.miss_start ? r_oldest : r_cur[SW-1:0];
        head_re = i_cmd.head_rd || i_cmd.ul_head_rd || i_cmd.ins_rd;
        head_ra = i_cmd.ul_head_rd ? r_b : r_h;

        head_we = 1'b0;
        head_wa = r_h;
        head_wd = NIL;
        if (i_cmd.clr_step) begin
            head_we = clr_head;
            head_wa = r_clr[HASH_BITS-1:0];
        end else if (i_cmd.ul_fix) begin
            head_we = (r_prev == NIL);
            head_wa = r_b;
            head_wd = nxt;
        end else if (i_cmd.ins_wr) begin
            head_we = 1'b1;
            head_wd = LW'(r_s);
        end

        link_we = 1'b0;
        link_wa = r_last[SW-1:0];
        link_wd = NIL;
        if (i_cmd.miss_start) begin
            link_we = trim;
        end else if (i_cmd.ul_fix) begin
            link_we = (r_prev != NIL);
            link_wa = r_prev[SW-1:0];
            link_wd = nxt;
        end else if (i_cmd.ins_wr) begin
            link_we = 1'b1;
            link_wa = r_s;
            link_wd = clip(head_rd);
        end

        used_we = (i_cmd.clr_step && clr_used) || i_cmd.ins_wr;
        used_wa = i_cmd.clr_step ? r_clr[SW-1:0] : r_s;
        used_wd = i_cmd.ins_wr;

        data_we   = i_cmd.hit_upd || i_cmd.ins_wr;
        data_wa   = i_cmd.ins_wr ? r_s : r_cur[SW-1:0];
        addr_wd   = r_dst;
        stamp_wd  = r_now;
        if (i_cmd.ins_wr) begin
            credit_wd = (r_init >= r_cost) ? (r_init - r_cost) : '0;
        end else begin
            credit_wd = raw ? (clamp - r_cost) : clamp;
        end
    end

    pacrl_ram #(.WIDTH(ADDR_W), .DEPTH(TABLE_ENTRIES)) u_addr (
        .i_clk(i_clk), .i_we(i_cmd.ins_wr), .i_waddr(r_s), .i_wdata(addr_wd),
        .i_re(slot_re), .i_raddr(slot_ra), .o_rdata(addr_rd)
    );

    pacrl_ram #(.WIDTH(TICK_W), .DEPTH(TABLE_ENTRIES)) u_stamp (
        .i_clk(i_clk), .i_we(data_we), .i_waddr(data_wa), .i_wdata(stamp_wd),
        .i_re(slot_re), .i_raddr(slot_ra), .o_rdata(stamp_rd)
    );

    pacrl_ram #(.WIDTH(CREDIT_W), .DEPTH(TABLE_ENTRIES)) u_credit (
        .i_clk(i_clk), .i_we(data_we), .i_waddr(data_wa), .i_wdata(credit_wd),
        .i_re(slot_re), .i_raddr(slot_ra), .o_rdata(credit_rd)
    );

    pacrl_ram #(.WIDTH(LW), .DEPTH(TABLE_ENTRIES)) u_link (
        .i_clk(i_clk), .i_we(link_we), .i_waddr(link_wa), .i_wdata(link_wd),
        .i_re(link_re), .i_raddr(slot_ra), .o_rdata(link_rd)
    );

    pacrl_ram #(.WIDTH(1), .DEPTH(TABLE_ENTRIES)) u_used (
        .i_clk(i_clk), .i_we(used_we), .i_waddr(used_wa), .i_wdata(used_wd),
        .i_re(slot_re), .i_raddr(slot_ra), .o_rdata(used_rd)
    );

    pacrl_ram #(.WIDTH(LW), .DEPTH(NB)) u_head (
        .i_clk(i_clk), .i_we(head_we), .i_waddr(head_wa), .i_wdata(head_wd),
        .i_re(head_re), .i_raddr(head_ra), .o_rdata(head_rd)
    );

    always_comb begin
        o_sts.clr_done    = (r_clr == CW'(CLR_N - 1));
        o_sts.src_zero    = (i_source_address == '0);
        o_sts.cur_end     = (r_cur == NIL) || (r_steps == LW'(TABLE_ENTRIES));
        o_sts.addr_match  = (addr_rd == r_dst);
        o_sts.cur_is_slot = (r_cur == LW'(r_s));
        o_sts.slot_used   = used_rd;
    end

    assign o_verdict = r_verdict;
    assign o_was_new = r_was_new;

`ifndef SYNTH
    a_hit_slot_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.hit_upd |-> r_cur != NIL)
        else $error("credit update on a null slot");
    a_oldest_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ins_wr |=> r_oldest != $past(r_oldest))
        else $error("oldest slot did not advance");
    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.walk_cmp || i_cmd.ul_adv) |-> r_steps < LW'(TABLE_ENTRIES))
        else $error("chain walk past table size");
`endif
endmodule

@@ design/pacrl_ctrl.sv @@
// ----------------------------------------------------------------------------
// pacrl_ctrl
// Controller: sequences clearing, chain lookup, credit update and slot reuse.
// ----------------------------------------------------------------------------
module pacrl_ctrl import pacrl_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR:    if (i_sts.clr_done) n_state = ST_IDLE;
            ST_IDLE: begin
                if (i_in_valid) n_state = i_sts.src_zero ? ST_OUT : ST_HEAD_RD;
            end
            ST_HEAD_RD:  n_state = ST_HEAD_WT;
            ST_HEAD_WT:  n_state = ST_WALK_CHK;
            ST_WALK_CHK: n_state = i_sts.cur_end ? ST_MISS : ST_WALK_CMP;
            ST_WALK_CMP: n_state = i_sts.addr_match ? ST_HIT_SUM : ST_WALK_CHK;
            ST_HIT_SUM:  n_state = ST_HIT_UPD;
            ST_HIT_UPD:  n_state = ST_OUT;
            ST_MISS:     n_state = ST_UL_HASH;
            ST_UL_HASH:  n_state = i_sts.slot_used ? ST_UL_HRD : ST_INS_RD;
            ST_UL_HRD:   n_state = ST_UL_HWT;
            ST_UL_HWT:   n_state = ST_UL_CHK;
            ST_UL_CHK: begin
                if (i_sts.cur_end) n_state = ST_INS_RD;
                else if (i_sts.cur_is_slot) n_state = ST_UL_FIX;
                else n_state = ST_UL_NXT;
            end
            ST_UL_NXT:   n_state = ST_UL_CHK;
            ST_UL_FIX:   n_state = ST_INS_RD;
            ST_INS_RD:   n_state = ST_INS_WR;
            ST_INS_WR:   n_state = ST_OUT;
            ST_OUT:      if (i_out_ready) n_state = ST_IDLE;
            default:     n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_CLEAR:    o_cmd.clr_step = 1'b1;
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_HEAD_RD:  o_cmd.head_rd = 1'b1;
            ST_HEAD_WT:  o_cmd.walk_init = 1'b1;
            ST_WALK_CHK: o_cmd.walk_rd = !i_sts.cur_end;
            ST_WALK_CMP: o_cmd.walk_cmp = 1'b1;
            ST_HIT_SUM:  o_cmd.hit_sum = 1'b1;
            ST_HIT_UPD:  o_cmd.hit_upd = 1'b1;
            ST_MISS:     o_cmd.miss_start = 1'b1;
            ST_UL_HASH:  o_cmd.ul_hash = 1'b1;
            ST_UL_HRD:   o_cmd.ul_head_rd = 1'b1;
            ST_UL_HWT:   o_cmd.ul_init = 1'b1;
            ST_UL_CHK:   o_cmd.ul_rd = !i_sts.cur_end;
            ST_UL_NXT:   o_cmd.ul_adv = 1'b1;
            ST_UL_FIX:   o_cmd.ul_fix = 1'b1;
            ST_INS_RD:   o_cmd.ins_rd = 1'b1;
            ST_INS_WR:   o_cmd.ins_wr = 1'b1;
            ST_OUT:      o_out_valid = 1'b1;
            default: ;
        endcase
    end

`ifndef SYNTH
    a_ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid)
        else $error("input taken while a verdict is pending");
    a_hit_after_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.hit_sum |=> o_cmd.hit_upd)
        else $error("credit sum not followed by update");
    a_insert_then_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.ins_wr |=> o_out_valid)
        else $error("insert not followed by verdict");
`endif
endmodule

@@ design/per_address_credit_rate_limiter_core.sv @@
// ----------------------------------------------------------------------------
// per_address_credit_rate_limiter_core
// Token-bucket rate limiter keyed by destination address, hashed chained table.
// ----------------------------------------------------------------------------
// Packets enter on i_req (source, destination, tick) with valid/ready; one
// verdict per packet leaves on o_rsp (verdict, was_new) with valid/ready.
// Registers are to be written over the APB port only while no packet is in
// flight; the user must keep to this, the block does not enforce it.
// After reset the block clears its bucket heads and slot valid bits, one per
// cycle, and holds i_req.ready low meanwhile. One packet is handled at a time:
//   zero source:     no table lookup; verdict and was_new are both 0
//   known address:   the chain is walked up to the hit, then the credit is
//                    summed, clamped and charged
//   new address:     the chain is walked to its end, the reused slot is
//                    unlinked from its old chain (skipped when that slot is
//                    still free), then the new entry is put at the head.
// Chain walks go one link at a time through the single read port of the link
// and address memories. The verdict waits in an output register while
// o_rsp.ready is low, and no new packet is taken until it has been delivered.
// ----------------------------------------------------------------------------
module per_address_credit_rate_limiter_core import pacrl_pkg::*; #(
    parameter int TABLE_ENTRIES = 256,
    parameter int HASH_BITS     = 9,
    parameter int CHAIN_LIMIT   = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pacrl_req_if.sink             i_req,
    pacrl_rsp_if.source           o_rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);
    t_cmd cmd;
    t_sts sts;
    logic in_ready, out_valid, verdict, was_new;

    assign pready = 1'b1;

    pacrl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .o_out_valid(out_valid),
        .i_out_ready(o_rsp.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pacrl_dp #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .HASH_BITS    (HASH_BITS),
        .CHAIN_LIMIT  (CHAIN_LIMIT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_source_address(i_req.source_address),
        .i_dest_address  (i_req.dest_address),
        .i_now_tick      (i_req.now_tick),
        .o_verdict       (verdict),
        .o_was_new       (was_new),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata)
    );

    assign i_req.ready   = in_ready;
    assign o_rsp.valid   = out_valid;
    assign o_rsp.verdict = verdict;
    assign o_rsp.was_new = was_new;
endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the per-address credit rate limiter core.
// ----------------------------------------------------------------------------
// Packets are sent on the request channel with random gaps while the verdict
// channel stalls at random. Each accepted packet runs through a local model of
// the hashed credit table, and each delivered verdict is checked against the
// oldest prediction. Registers are written over APB only while the core is
// idle. Directed cases cover zero source and destination, field extremes,
// tick wrap and chain trimming; random phases follow, which also reuse slots,
// with one long stall of the verdict channel.
// ----------------------------------------------------------------------------
module tb;
    import pacrl_pkg::*;

    localparam int          SLOTS      = 256;
    localparam int          HBITS      = 9;
    localparam int          NBUCKETS   = 1 << HBITS;
    localparam int          MAX_CHAIN  = 16;
    localparam logic [8:0]  NIL        = 9'd256;
    localparam int          SETTLE     = 80;
    localparam int          WDOG_LIMIT = 6000;

    typedef struct packed {
        logic verdict;
        logic was_new;
    } t_verdict;

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    pacrl_req_if req_ch ();
    pacrl_rsp_if rsp_ch ();

    per_address_credit_rate_limiter_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // local copy of the rate table
    logic [31:0] cfg_init_credit;
    logic [31:0] cfg_ceiling;
    logic [31:0] cfg_cost;
    logic        cfg_invert;
    logic [31:0] slot_addr [SLOTS];
    logic [31:0] slot_stamp [SLOTS];
    logic [31:0] slot_credit [SLOTS];
    logic [8:0]  slot_link [SLOTS];
    logic        slot_used [SLOTS];
    logic [8:0]  bucket_first [NBUCKETS];
    logic [7:0]  next_victim;

    t_verdict    pending_verdicts [$];
    int          fail_count;
    int          idle_cycles;
    bit          no_idle;
    int          hold_len;
    logic [31:0] tick_now;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [8:0] fold_addr(logic [31:0] a);
        logic [31:0] h;
        h = '0;
        do begin
            h ^= a;
            a >>= HBITS;
        end while (a != 0);
        return h[8:0];
    endfunction

    function automatic logic [8:0] link_after(logic [8:0] s);
        if (s >= NIL) return NIL;
        return (slot_link[s] < NIL) ? slot_link[s] : NIL;
    endfunction

    function automatic void unchain_slot(logic [8:0] s);
        logic [8:0] b;
        logic [8:0] cur;
        logic [8:0] prev;
        int         steps;
        if (!slot_used[s]) return;
        b     = fold_addr(slot_addr[s]);
        cur   = (bucket_first[b] < NIL) ? bucket_first[b] : NIL;
        prev  = NIL;
        steps = 0;
        while (cur != NIL && steps < SLOTS) begin
            if (cur == s) begin
                if (prev != NIL) slot_link[prev] = link_after(s);
                else bucket_first[b] = link_after(s);
                return;
            end
            prev = cur;
            cur  = link_after(cur);
            steps++;
        end
    endfunction

    function automatic void clear_table();
        cfg_init_credit = '0;
        cfg_ceiling     = '0;
        cfg_cost        = '0;
        cfg_invert      = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            slot_addr[i]   = '0;
            slot_stamp[i]  = '0;
            slot_credit[i] = '0;
            slot_link[i]   = NIL;
            slot_used[i]   = 1'b0;
        end
        for (int i = 0; i < NBUCKETS; i++) bucket_first[i] = NIL;
        next_victim = '0;
    endfunction

    function automatic t_verdict rate_check(logic [31:0] src, logic [31:0] dst,
                                            logic [31:0] now);
        t_verdict    r;
        logic [8:0]  h;
        logic [8:0]  cur;
        logic [8:0]  last;
        logic [8:0]  hit;
        logic [8:0]  s;
        int          passed;
        int          steps;
        logic [63:0] c;
        logic [31:0] dt;
        if (src == 0) begin
            r = '0;
            return r;
        end
        h      = fold_addr(dst);
        cur    = (bucket_first[h] < NIL) ? bucket_first[h] : NIL;
        last   = NIL;
        hit    = NIL;
        passed = 0;
        steps  = 0;
        while (cur != NIL && steps < SLOTS) begin
            if (slot_addr[cur] == dst) begin
                hit = cur;
                break;
            end
            passed++;
            if (link_after(cur) != NIL) last = cur;
            cur = link_after(cur);
            steps++;
        end
        if (hit != NIL) begin
            dt = now - slot_stamp[hit];
            c  = 64'(slot_credit[hit]) + 64'(dt) * 64'd128;
            if (c > 64'(cfg_ceiling)) c = 64'(cfg_ceiling);
            slot_stamp[hit] = now;
            r.was_new = 1'b0;
            if (c >= 64'(cfg_cost)) begin
                c = c - 64'(cfg_cost);
                r.verdict = 1'b1 ^ cfg_invert;
            end else begin
                r.verdict = cfg_invert;
            end
            slot_credit[hit] = c[31:0];
            return r;
        end
        if (passed >= MAX_CHAIN && last != NIL) slot_link[last] = NIL;
        s = {1'b0, next_victim};
        unchain_slot(s);
        next_victim     = next_victim + 8'd1;
        slot_link[s]    = (bucket_first[h] < NIL) ? bucket_first[h] : NIL;
        bucket_first[h] = s;
        slot_used[s]    = 1'b1;
        slot_addr[s]    = dst;
        slot_stamp[s]   = now;
        slot_credit[s]  = (cfg_init_credit >= cfg_cost) ? cfg_init_credit - cfg_cost : '0;
        r.verdict = 1'b1 ^ cfg_invert;
        r.was_new = 1'b1;
        return r;
    endfunction

    // address that lands in bucket b; k selects one of 32 such addresses
    function automatic logic [31:0] bucket_addr(logic [8:0] b, logic [4:0] k);
        return {18'd0, k, b ^ {4'd0, k}};
    endfunction

    task automatic send_packet(logic [31:0] src, logic [31:0] dst, logic [31:0] now);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.source_address = src;
        req_ch.dest_address   = dst;
        req_ch.now_tick       = now;
        req_ch.valid          = 1'b1;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        pending_verdicts.push_back(rate_check(src, dst, now));
        @(negedge i_clk);
    endtask

    task automatic go_idle();
        req_ch.valid = 1'b0;
        while (pending_verdicts.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [31:0] value);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = APB_ADDR_W'({idx, 2'b00});
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_INITIAL_CREDIT: cfg_init_credit = value;
            REG_CREDIT_CEILING: cfg_ceiling     = value;
            REG_PASS_COST:      cfg_cost        = value;
            REG_INVERT_VERDICT: cfg_invert      = value[0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_rates(logic [31:0] init_c, logic [31:0] ceil_c,
                             logic [31:0] cost, logic inv);
        go_idle();
        apb_write(REG_INITIAL_CREDIT, init_c);
        apb_write(REG_CREDIT_CEILING, ceil_c);
        apb_write(REG_PASS_COST, cost);
        apb_write(REG_INVERT_VERDICT, {31'd0, inv});
    endtask

    function automatic logic [31:0] next_tick();
        if ($urandom_range(0, 15) == 0) tick_now = $urandom();
        else tick_now = tick_now + $urandom_range(0, 3);
        return tick_now;
    endfunction

    task automatic test_special_cases();
        set_rates(32'd300, 32'd1000, 32'd200, 1'b0);
        send_packet(32'h0, 32'h1234_5678, 32'd10);
        send_packet(32'hFFFF_FFFF, 32'h0, 32'd0);
        send_packet(32'h0000_0001, 32'h0, 32'd0);
        send_packet(32'h0000_0001, 32'h0, 32'd1);
        send_packet(32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_packet(32'h1, 32'hFFFF_FFFF, 32'h0000_0002);
        send_packet(32'h1, 32'hFFFF_FFFF, 32'h0000_0001);
        send_packet(32'h0, 32'hFFFF_FFFF, 32'h0000_0005);
        send_packet(32'h5555_5555, 32'hFFFF_FFFF, 32'h0000_0005);
        send_packet(32'hAAAA_AAAA, 32'hFFFF_FFFF, 32'h0000_0005);
        set_rates(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_packet(32'h1, 32'hDEAD_BEEF, 32'd100);
        send_packet(32'h1, 32'hDEAD_BEEF, 32'd99);
        send_packet(32'h0, 32'hDEAD_BEEF, 32'd100);
    endtask

    task automatic test_chain_trim();
        set_rates(32'd0, 32'hFFFF_FFFF, 32'd1, 1'b0);
        for (int k = 0; k < 20; k++) send_packet(32'h1, bucket_addr(9'd77, 5'(k)), 32'd50);
        send_packet(32'h1, bucket_addr(9'd77, 5'd19), 32'd51);
        send_packet(32'h1, bucket_addr(9'd77, 5'd0), 32'd52);
    endtask

    task automatic test_random_phase(int count, int pool_bits);
        logic [8:0]  hot [4];
        logic [31:0] src;
        logic [31:0] dst;
        for (int i = 0; i < 4; i++) hot[i] = 9'($urandom_range(0, NBUCKETS - 1));
        for (int n = 0; n < count; n++) begin
            if (n % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
            src = ($urandom_range(0, 15) == 0) ? 32'h0 : $urandom();
            if ($urandom_range(0, 9) < 7)
                dst = bucket_addr(hot[$urandom_range(0, pool_bits)], 5'($urandom_range(0, 31)));
            else
                dst = $urandom();
            send_packet(src, dst, next_tick());
        end
        no_idle = 1'b0;
    endtask

    task automatic test_backpressure();
        go_idle();
        no_idle  = 1'b1;
        hold_len = 300;
        for (int n = 0; n < 40; n++)
            send_packet(32'h1, bucket_addr(9'd3, 5'($urandom_range(0, 31))), next_tick());
        no_idle = 1'b0;
    endtask

    // verdict side: random stalls, one long hold on request
    initial begin
        int w;
        rsp_ch.ready = 1'b0;
        forever begin
            if (hold_len > 0) begin
                rsp_ch.ready = 1'b0;
                repeat (hold_len) @(negedge i_clk);
                hold_len = 0;
            end
            w = no_idle ? 0 : $urandom_range(0, 7);
            if (w > 0) begin
                rsp_ch.ready = 1'b0;
                repeat (w) @(negedge i_clk);
            end
            rsp_ch.ready = 1'b1;
            @(posedge i_clk);
            while (!(rsp_ch.valid && rsp_ch.ready)) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_verdict exp_v;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_verdicts.size() == 0) begin
                $error("unexpected verdict item: verdict=%0b was_new=%0b",
                       rsp_ch.verdict, rsp_ch.was_new);
                fail_count++;
            end else begin
                exp_v = pending_verdicts.pop_front();
                if (rsp_ch.verdict !== exp_v.verdict) begin
                    $error("verdict: expected %0b, got %0b", exp_v.verdict, rsp_ch.verdict);
                    fail_count++;
                end
                if (rsp_ch.was_new !== exp_v.was_new) begin
                    $error("was_new: expected %0b, got %0b", exp_v.was_new, rsp_ch.was_new);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
                || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n               = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        req_ch.valid          = 1'b0;
        req_ch.source_address = '0;
        req_ch.dest_address   = '0;
        req_ch.now_tick       = '0;
        fail_count            = 0;
        idle_cycles           = 0;
        no_idle               = 1'b0;
        hold_len              = 0;
        tick_now              = '0;
        clear_table();
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_special_cases();
        test_chain_trim();
        set_rates(32'd300, 32'd1000, 32'd200, 1'b0);
        test_random_phase(300, 3);
        test_backpressure();
        set_rates(32'd0, 32'hFFFF_FFFF, 32'd128, 1'b1);
        test_random_phase(300, 1);
        set_rates(32'hFFFF_FFFF, 32'd0, 32'd0, 1'b0);
        test_random_phase(250, 0);
        set_rates(32'd100, 32'd400, 32'd300, 1'b1);
        test_random_phase(300, 3);
        set_rates(32'd0, 32'd0, 32'hFFFF_FFFF, 1'b0);
        test_random_phase(200, 2);

        go_idle();
        if (fail_count == 0 && pending_verdicts.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
